FILE: src/sha1_pkg.sv
package sha1_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned NumWords  = 16;
  localparam int unsigned NumDigest = 5;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hefcdab89;
  localparam logic [31:0] H2 = 32'h98badcfe;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hc3d2e1f0;
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;
  localparam logic [7:0]  PadMark = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  typedef enum logic [2:0] {
    StIdle,
    StPack,
    StRound,
    StAdd,
    StPad,
    StEmit
  } state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] a, b, c, d, e;
  } rnd_ctrl_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

endpackage

FILE: src/sha1_if.sv
interface sha1_in_if;
  import sha1_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha1_out_if;
  import sha1_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/sha1_round.sv
module sha1_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha1_pkg::rnd_ctrl_t ctrl_i,
  input  logic                step_i,
  input  logic [31:0]         w_i,
  output logic [31:0]         a_o,
  output logic [31:0]         b_o,
  output logic [31:0]         c_o,
  output logic [31:0]         d_o,
  output logic [31:0]         e_o,
  output logic [6:0]          round_o,
  output logic                done_o
);
  import sha1_pkg::*;

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] f, k, t;
  logic [6:0]  r_q;

  always_comb begin
    if (r_q < 7'd20) begin
      f = d_q ^ (b_q & (c_q ^ d_q));
      k = K0;
    end else if (r_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = K1;
    end else if (r_q < 7'd60) begin
      f = (b_q & c_q) | (d_q & (b_q | c_q));
      k = K2;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = K3;
    end
    t = rotl(a_q, 5) + f + e_q + k + w_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q <= ctrl_i.a;
      b_q <= ctrl_i.b;
      c_q <= ctrl_i.c;
      d_q <= ctrl_i.d;
      e_q <= ctrl_i.e;
    end else if (step_i) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= rotl(b_q, 30);
      b_q <= a_q;
      a_q <= t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (ctrl_i.start) begin
      r_q <= '0;
    end else if (step_i) begin
      r_q <= done_o ? 7'd0 : r_q + 7'd1;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;
  assign c_o = c_q;
  assign d_o = d_q;
  assign e_o = e_q;
  assign round_o = r_q;
  assign done_o = (r_q == 7'(NumRounds - 1)) && step_i;

  property p_start_step_apart;
    @(posedge clk_i) disable iff (!rst_ni) !(ctrl_i.start && step_i);
  endproperty
  assert property (p_start_step_apart) else $error("round start and step together");

  property p_round_range;
    @(posedge clk_i) disable iff (!rst_ni) r_q < 7'(NumRounds);
  endproperty
  assert property (p_round_range) else $error("round counter out of range");

  property p_start_clears;
    @(posedge clk_i) disable iff (!rst_ni) ctrl_i.start |=> r_q == 7'd0;
  endproperty
  assert property (p_start_clears) else $error("round counter not cleared on start");
endmodule

FILE: src/sha1_message_digest_core.sv
// Channel | Dir | Beat payload
// in_if   | in  | data_byte, byte_present, end_of_message
// out_if  | out | digest_word, word_index, last_word
// A plain byte is taken in StIdle and then packed into the block in StPack.
// A byte that fills a block goes on to the 80 rounds in the single shared round unit
// (StRound) and then to the add back (StAdd).
// A closing beat pads one byte per StPad and StPack pass, compresses once or twice, then
// gives five output beats; ready stays low until the last of them is taken.
// Reset loads the initial hash values and clears the counters.
module sha1_message_digest_core (
  input logic       clk_i,
  input logic       rst_ni,
  sha1_in_if.sink   in_if,
  sha1_out_if.source out_if
);
  import sha1_pkg::*;

  state_e state_q, state_d;
  logic [31:0] h_q [NumDigest];
  logic [31:0] w_q [NumWords];
  logic [63:0] cnt_q;
  logic [5:0]  fill_q;
  logic        last_q;
  logic [7:0]  byte_q;
  logic [4:0]  pad_q;
  logic [2:0]  idx_q;

  rnd_ctrl_t   rc;
  logic        step, rdone;
  logic [31:0] ra, rb, rc_o, rd, re, w_cur, w_new;
  logic [6:0]  rnd;
  logic        accept, full;
  logic [63:0] bits;
  logic [7:0]  pad_byte;

  assign accept = in_if.valid && in_if.ready;
  assign full   = (fill_q == 6'd63);
  assign bits   = {cnt_q[60:0], 3'b000};

  always_comb begin
    case (pad_q)
      5'd0: pad_byte = PadMark;
      5'd1: pad_byte = (fill_q == 6'd56) ? bits[63:56] : 8'h00;
      5'd2: pad_byte = bits[55:48];
      5'd3: pad_byte = bits[47:40];
      5'd4: pad_byte = bits[39:32];
      5'd5: pad_byte = bits[31:24];
      5'd6: pad_byte = bits[23:16];
      5'd7: pad_byte = bits[15:8];
      5'd8: pad_byte = bits[7:0];
      default: pad_byte = 8'h00;
    endcase
  end

  assign w_new = rotl(w_q[rnd[3:0]] ^ w_q[4'(rnd[3:0] + 4'd2)] ^
                      w_q[4'(rnd[3:0] + 4'd8)] ^ w_q[4'(rnd[3:0] + 4'd13)], 1);
  assign w_cur = (rnd < 7'd16) ? w_q[rnd[3:0]] : w_new;

  assign step = (state_q == StRound);
  always_comb begin
    rc.start = (state_q == StPack) && full;
    rc.a = h_q[0];
    rc.b = h_q[1];
    rc.c = h_q[2];
    rc.d = h_q[3];
    rc.e = h_q[4];
  end

  sha1_round u_round (
    .clk_i, .rst_ni, .ctrl_i(rc), .step_i(step), .w_i(w_cur),
    .a_o(ra), .b_o(rb), .c_o(rc_o), .d_o(rd), .e_o(re),
    .round_o(rnd), .done_o(rdone)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (in_if.data.byte_present) state_d = StPack;
          else if (in_if.data.end_of_message) state_d = StPad;
        end
      end
      StPack: state_d = full ? StRound : (last_q ? StPad : StIdle);
      StRound: if (rdone) state_d = StAdd;
      StAdd: begin
        if (!last_q) state_d = StIdle;
        else if (pad_q == 5'd9) state_d = StEmit;
        else state_d = StPad;
      end
      StPad: state_d = StPack;
      StEmit: if (out_if.ready && idx_q == 3'd4) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_if.ready = (state_q == StIdle);
    out_if.valid = (state_q == StEmit);
    out_if.data.digest_word = h_q[idx_q];
    out_if.data.word_index = idx_q;
    out_if.data.last_word = (idx_q == 3'd4);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      h_q <= '{H0, H1, H2, H3, H4};
      cnt_q <= '0;
      fill_q <= '0;
      last_q <= 1'b0;
      pad_q <= '0;
      idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StIdle && accept) begin
        last_q <= in_if.data.end_of_message;
        pad_q <= '0;
        idx_q <= '0;
        if (in_if.data.byte_present) cnt_q <= cnt_q + 64'd1;
      end
      if (state_q == StPack) fill_q <= fill_q + 6'd1;
      if (state_q == StPad) begin
        if (pad_q != 5'd1 || fill_q == 6'd56) pad_q <= pad_q + 5'd1;
      end
      if (state_q == StAdd) begin
        h_q[0] <= h_q[0] + ra;
        h_q[1] <= h_q[1] + rb;
        h_q[2] <= h_q[2] + rc_o;
        h_q[3] <= h_q[3] + rd;
        h_q[4] <= h_q[4] + re;
      end
      if (state_q == StEmit && out_if.ready) begin
        if (idx_q == 3'd4) begin
          idx_q <= '0;
          h_q <= '{H0, H1, H2, H3, H4};
          cnt_q <= '0;
          fill_q <= '0;
          last_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && accept) begin
      byte_q <= in_if.data.data_byte;
    end else if (state_q == StPad) begin
      byte_q <= pad_byte;
    end
    if (state_q == StPack) begin
      if (fill_q[1:0] == 2'd0) w_q[fill_q[5:2]] <= {byte_q, 24'h0};
      else w_q[fill_q[5:2]][8*(2'd3 - fill_q[1:0]) +: 8] <= byte_q;
    end else if (step && rnd >= 7'd16) begin
      w_q[rnd[3:0]] <= w_new;
    end
  end

  property p_ready_idle;
    @(posedge clk_i) disable iff (!rst_ni) in_if.ready |-> !out_if.valid;
  endproperty
  assert property (p_ready_idle) else $error("ready during output");

  property p_emit_words;
    @(posedge clk_i) disable iff (!rst_ni) out_if.valid |-> idx_q <= 3'd4;
  endproperty
  assert property (p_emit_words) else $error("bad word index");

  property p_round_zero;
    @(posedge clk_i) disable iff (!rst_ni) (state_q == StIdle) |-> rnd == 7'd0;
  endproperty
  assert property (p_round_zero) else $error("round counter not idle");
endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sha1_pkg::*;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned RandomItems = 430;

  typedef struct {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
    logic       has_digest;
    logic [31:0] digest [NumDigest];
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sha1_in_if  in_if ();
  sha1_out_if out_if ();

  sha1_message_digest_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [31:0] chain_q [NumDigest];
  logic [31:0] block_q [NumWords];
  logic [63:0] byte_count_q;
  int unsigned fill_q;

  out_beat_t digest_queue [$];
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned beats_seen = 0;
  int unsigned messages_sent = 0;
  int unsigned out_wait = 0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] rot_left(logic [31:0] v, int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  task automatic hash_reset_state();
    chain_q[0] = H0; chain_q[1] = H1; chain_q[2] = H2; chain_q[3] = H3; chain_q[4] = H4;
    byte_count_q = '0;
    fill_q = 0;
  endtask

  task automatic compress();
    logic [31:0] a, b, c, d, e, w, f, k, t;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int r = 0; r < NumRounds; r++) begin
      if (r < 16) begin
        w = block_q[r & 15];
      end else begin
        w = rot_left(block_q[r & 15] ^ block_q[(r + 2) & 15] ^ block_q[(r + 8) & 15]
                     ^ block_q[(r + 13) & 15], 1);
        block_q[r & 15] = w;
      end
      if (r < 20) begin
        f = d ^ (b & (c ^ d)); k = K0;
      end else if (r < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c)); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      t = rot_left(a, 5) + f + e + k + w;
      e = d; d = c; c = rot_left(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic pack_byte(logic [7:0] v);
    int unsigned wi;
    wi = fill_q >> 2;
    if ((fill_q & 3) == 0) block_q[wi] = '0;
    block_q[wi] |= 32'(v) << ((3 - (fill_q & 3)) * 8);
    fill_q++;
    if (fill_q == 64) begin
      compress();
      fill_q = 0;
    end
  endtask

  task automatic predict_digest(logic [7:0] data_byte, logic present, logic closing);
    logic [63:0] bits;
    out_beat_t beat;
    if (present) begin
      pack_byte(data_byte);
      byte_count_q++;
    end
    if (!closing) return;
    bits = byte_count_q << 3;
    pack_byte(PadMark);
    while (fill_q != 56) pack_byte(8'h00);
    for (int i = 7; i >= 0; i--) pack_byte(bits[i*8 +: 8]);
    for (int i = 0; i < NumDigest; i++) begin
      beat.digest_word = chain_q[i];
      beat.word_index = 3'(i);
      beat.last_word = (i == NumDigest - 1);
      digest_queue.push_back(beat);
    end
    hash_reset_state();
  endtask

  task automatic send_beat(logic [7:0] data_byte, logic present, logic closing);
    int unsigned gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= '{data_byte: data_byte, byte_present: present, end_of_message: closing};
    predict_digest(data_byte, present, closing);
    if (closing) messages_sent++;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic add_row(ref stim_row_t rows[$], input logic [7:0] v, input logic p,
                         input logic c);
    stim_row_t row;
    row.data_byte = v; row.byte_present = p; row.end_of_message = c; row.has_digest = 0;
    rows.push_back(row);
  endtask

  initial begin
    stim_row_t rows [$];
    stim_row_t row;
    int unsigned len;
    int unsigned sent;
    in_if.valid = 1'b0;
    in_if.data = '0;
    hash_reset_state();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(rows, 8'h00, 1'b0, 1'b1);
    rows[0].has_digest = 1;
    rows[0].digest = '{32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709};
    add_row(rows, 8'h61, 1'b1, 1'b0);
    add_row(rows, 8'h62, 1'b1, 1'b0);
    add_row(rows, 8'h55, 1'b0, 1'b0);
    add_row(rows, 8'h63, 1'b1, 1'b1);
    rows[4].has_digest = 1;
    rows[4].digest = '{32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d};
    add_row(rows, 8'hff, 1'b1, 1'b1);
    add_row(rows, 8'h00, 1'b1, 1'b0);
    add_row(rows, 8'hff, 1'b1, 1'b0);
    add_row(rows, 8'haa, 1'b0, 1'b0);
    add_row(rows, 8'h00, 1'b0, 1'b1);
    for (int i = 0; i < 14; i++) add_row(rows, 8'(i * 37), 1'b1, 1'b0);
    add_row(rows, 8'h80, 1'b1, 1'b1);

    foreach (rows[i]) begin
      row = rows[i];
      if (row.has_digest) begin
        if (digest_queue.size() != 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("directed digest table out of step");
        end
        send_beat(row.data_byte, row.byte_present, row.end_of_message);
        for (int j = 0; j < NumDigest; j++) begin
          if (digest_queue[j].digest_word !== row.digest[j]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("known digest word %0d: expected %h actual %h", j, row.digest[j],
                       digest_queue[j].digest_word);
          end
        end
      end else begin
        send_beat(row.data_byte, row.byte_present, row.end_of_message);
      end
    end

    sent = 0;
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(55, 57);
        1: len = $urandom_range(63, 65);
        2: len = $urandom_range(119, 129);
        default: len = $urandom_range(0, 12);
      endcase
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
        send_beat(8'($urandom), 1'b1, 1'b0);
        sent++;
      end
      if ($urandom_range(0, 1)) send_beat(8'($urandom), 1'b1, 1'b1);
      else send_beat(8'($urandom), 1'b0, 1'b1);
      sent++;
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wait = $urandom_range(0, 8);
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) out_wait = $urandom_range(0, 8);
      else if (out_wait != 0) out_wait--;
      out_if.ready <= (out_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_seen++;
      if (digest_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected digest beat %p", out_if.data);
      end else begin
        want = digest_queue.pop_front();
        if (out_if.data.digest_word !== want.digest_word ||
            out_if.data.word_index !== want.word_index ||
            out_if.data.last_word !== want.last_word) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("digest beat mismatch: expected %h/%0d/%b actual %h/%0d/%b",
                     want.digest_word, want.word_index, want.last_word,
                     out_if.data.digest_word, out_if.data.word_index,
                     out_if.data.last_word);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sha1_message_digest_core test failed");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (digest_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("Hashed %0d messages and checked %0d digest beats.", messages_sent, beats_seen);
    $display("Mismatches counted: %0d.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("sha1_message_digest_core test passed");
    end else begin
      $display("sha1_message_digest_core test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/sha1_pkg.sv
src/sha1_if.sv
src/sha1_round.sv
src/sha1_message_digest_core.sv
tb/sv/tb_top.sv
